>>> hw/rtl/icotri_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package icotri_pkg;
    localparam int DEF_INDEX_BITS    = 20;
    localparam int DEF_FRAC_BITS     = 14;
    localparam int RESET_FIRST_INDEX = 12;
    localparam int COORD_W           = 16;
    localparam int SUM_W             = COORD_W + 1;
    localparam int BIT_W             = 5;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_TRI   = 1'b1;

    localparam logic [2:0] EMIT_PAB   = 3'd0;
    localparam logic [2:0] EMIT_PBC   = 3'd1;
    localparam logic [2:0] EMIT_PCA   = 3'd2;
    localparam logic [2:0] EMIT_TRI_A = 3'd3;
    localparam logic [2:0] EMIT_TRI_B = 3'd4;
    localparam logic [2:0] EMIT_TRI_C = 3'd5;
    localparam logic [2:0] EMIT_INNER = 3'd6;

    typedef struct packed {
        logic             capture;
        logic             cfg_load;
        logic             sum_en;
        logic             sq_en;
        logic             load_en;
        logic             iter_en;
        logic             store_en;
        logic             emit_load;
        logic [1:0]       edge_sel;
        logic [1:0]       comp_sel;
        logic [BIT_W-1:0] bit_sel;
        logic [2:0]       emit_sel;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
    } sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/icosphere_triangle_subdivider_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Icosphere midpoint subdivider: one triangle request in, seven results out.
// Input channel (in_valid/in_ready) takes three corner indices and Q1.14
// corners. Output channel (out_valid/out_ready) gives three new points
// (edges ab, bc, ca) then four triangles; last_of_run marks the seventh.
// Config channel (cfg_valid/cfg_ready) loads the running point index and is
// always ready. It must be written only while the block is idle; the block
// itself does not enforce this. One shared bit-serial normaliser handles all
// nine components in turn: per edge a sum step and three square steps, then
// per component a load, one step per result bit and a store; then the seven
// results are presented. A zero-length sum skips its bit steps.
// A new request is accepted once the seventh result is in the output
// register, while it still waits to be taken.
// When the receiver stalls the output register holds and the block waits.
// Reset clears the controller and loads the running index with 12.
module icosphere_triangle_subdivider_core #(
    parameter int INDEX_BITS      = icotri_pkg::DEF_INDEX_BITS,
    parameter int COORD_FRAC_BITS = icotri_pkg::DEF_FRAC_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [INDEX_BITS-1:0]             index_a,
    input  wire logic [INDEX_BITS-1:0]             index_b,
    input  wire logic [INDEX_BITS-1:0]             index_c,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_a_x,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_a_y,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_a_z,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_b_x,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_b_y,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_b_z,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_c_x,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_c_y,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_c_z,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   item_kind,
    output logic [INDEX_BITS-1:0]                  out_index_first,
    output logic [INDEX_BITS-1:0]                  out_index_second,
    output logic [INDEX_BITS-1:0]                  out_index_third,
    output logic signed [icotri_pkg::COORD_W-1:0]  point_x,
    output logic signed [icotri_pkg::COORD_W-1:0]  point_y,
    output logic signed [icotri_pkg::COORD_W-1:0]  point_z,
    output logic                                   index_overflow,
    output logic                                   last_of_run,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [INDEX_BITS-1:0]             cfg_data
);
    import icotri_pkg::*;

    cmd_t cmd;
    sts_t sts;

    icotri_ctrl #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    icotri_datapath #(
        .INDEX_BITS     (INDEX_BITS),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .cmd             (cmd),
        .sts             (sts),
        .rst_n           (rst_n),
        .cfg_data        (cfg_data),
        .index_a         (index_a),
        .index_b         (index_b),
        .index_c         (index_c),
        .corner_a_x      (corner_a_x),
        .corner_a_y      (corner_a_y),
        .corner_a_z      (corner_a_z),
        .corner_b_x      (corner_b_x),
        .corner_b_y      (corner_b_y),
        .corner_b_z      (corner_b_z),
        .corner_c_x      (corner_c_x),
        .corner_c_y      (corner_c_y),
        .corner_c_z      (corner_c_z),
        .item_kind       (item_kind),
        .out_index_first (out_index_first),
        .out_index_second(out_index_second),
        .out_index_third (out_index_third),
        .point_x         (point_x),
        .point_y         (point_y),
        .point_z         (point_z),
        .index_overflow  (index_overflow),
        .last_of_run     (last_of_run)
    );
endmodule
`default_nettype wire

>>> hw/rtl/icotri_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module icotri_datapath #(
    parameter int INDEX_BITS      = icotri_pkg::DEF_INDEX_BITS,
    parameter int COORD_FRAC_BITS = icotri_pkg::DEF_FRAC_BITS
) (
    input  wire logic                              clk,
    input  wire icotri_pkg::cmd_t                  cmd,
    output icotri_pkg::sts_t                       sts,
    input  wire logic                              rst_n,
    input  wire logic [INDEX_BITS-1:0]             cfg_data,
    input  wire logic [INDEX_BITS-1:0]             index_a,
    input  wire logic [INDEX_BITS-1:0]             index_b,
    input  wire logic [INDEX_BITS-1:0]             index_c,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_a_x,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_a_y,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_a_z,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_b_x,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_b_y,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_b_z,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_c_x,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_c_y,
    input  wire logic signed [icotri_pkg::COORD_W-1:0] corner_c_z,
    output logic                                   item_kind,
    output logic [INDEX_BITS-1:0]                  out_index_first,
    output logic [INDEX_BITS-1:0]                  out_index_second,
    output logic [INDEX_BITS-1:0]                  out_index_third,
    output logic signed [icotri_pkg::COORD_W-1:0]  point_x,
    output logic signed [icotri_pkg::COORD_W-1:0]  point_y,
    output logic signed [icotri_pkg::COORD_W-1:0]  point_z,
    output logic                                   index_overflow,
    output logic                                   last_of_run
);
    import icotri_pkg::*;

    localparam int F   = COORD_FRAC_BITS;
    localparam int NW  = 2 * SUM_W + 2;
    localparam int PW  = NW + 2 * F + 6;
    localparam int RXW = F + 2 + COORD_W;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

    function automatic logic signed [PW-1:0] r2_eff(input logic [2*SUM_W-1:0] m2);
        logic [PW-1:0] t;
        t = PW'(m2) << (2 * F + 2);
        return $signed(t);
    endfunction

    logic [INDEX_BITS-1:0]        next_idx_reg;
    logic [INDEX_BITS-1:0]        ia_reg, ib_reg, ic_reg;
    logic [INDEX_BITS-1:0]        nidx_reg [3];
    logic                         ovf_reg;
    logic signed [COORD_W-1:0]    cor_reg [3][3];
    logic signed [SUM_W-1:0]      s_reg [3];
    logic [NW-1:0]                n_reg;
    logic [SUM_W-1:0]             mag_reg;
    logic                         neg_reg;
    logic signed [PW-1:0]         p_reg, q_reg;
    logic [F:0]                   r_reg;
    logic signed [COORD_W-1:0]    pts_reg [3][3];

    logic [INDEX_BITS+1:0]        ext [4];
    logic [INDEX_BITS-1:0]        nidx_next [3];
    logic                         ovf_next;
    logic [1:0]                   pi, qi;
    logic signed [2*SUM_W-1:0]    sq;
    logic signed [PW-1:0]         n_ext, p_cand;
    logic [SUM_W-1:0]             mag_next;
    logic [2*SUM_W-1:0]           mag_sq;
    logic [RXW-1:0]               rx;
    logic [COORD_W-1:0]           res;

    always_comb
    begin
        ovf_next = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            ext[k] = {2'b00, next_idx_reg} + (INDEX_BITS + 2)'(k);
        end
        for (int k = 0; k < 3; k++)
        begin
            if (ext[k][INDEX_BITS+1:INDEX_BITS] != 2'b00)
            begin
                nidx_next[k] = IDX_MAX;
                ovf_next     = 1'b1;
            end
            else
            begin
                nidx_next[k] = ext[k][INDEX_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        case (cmd.edge_sel)
            2'd0:
            begin
                pi = 2'd0;
                qi = 2'd1;
            end
            2'd1:
            begin
                pi = 2'd1;
                qi = 2'd2;
            end
            default:
            begin
                pi = 2'd2;
                qi = 2'd0;
            end
        endcase
    end

    assign sq       = s_reg[cmd.comp_sel] * s_reg[cmd.comp_sel];
    assign n_ext    = $signed(PW'(n_reg));
    assign mag_next = s_reg[cmd.comp_sel][SUM_W-1] ? SUM_W'(-s_reg[cmd.comp_sel])
                                                  : SUM_W'(s_reg[cmd.comp_sel]);
    assign mag_sq   = mag_reg * mag_reg;
    assign p_cand   = p_reg + (q_reg <<< ({1'b0, cmd.bit_sel} + 6'd2))
                    + (n_ext <<< ({cmd.bit_sel, 1'b0} + 6'd2));
    assign rx       = neg_reg ? RXW'(-$signed(RXW'(r_reg))) : RXW'(r_reg);
    assign res      = (n_reg == '0) ? '0 : rx[COORD_W-1:0];
    assign sts.n_zero = (n_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_idx_reg <= INDEX_BITS'(RESET_FIRST_INDEX);
        end
        else if (cmd.cfg_load)
        begin
            next_idx_reg <= cfg_data;
        end
        else if (cmd.capture)
        begin
            next_idx_reg <= (ext[3][INDEX_BITS+1:INDEX_BITS] != 2'b00)
                            ? IDX_MAX : ext[3][INDEX_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ia_reg <= index_a;
            ib_reg <= index_b;
            ic_reg <= index_c;
            for (int k = 0; k < 3; k++)
            begin
                nidx_reg[k] <= nidx_next[k];
            end
            ovf_reg <= ovf_next;
            cor_reg[0][0] <= corner_a_x;
            cor_reg[0][1] <= corner_a_y;
            cor_reg[0][2] <= corner_a_z;
            cor_reg[1][0] <= corner_b_x;
            cor_reg[1][1] <= corner_b_y;
            cor_reg[1][2] <= corner_b_z;
            cor_reg[2][0] <= corner_c_x;
            cor_reg[2][1] <= corner_c_y;
            cor_reg[2][2] <= corner_c_z;
        end
        if (cmd.sum_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s_reg[k] <= SUM_W'(cor_reg[pi][k]) + SUM_W'(cor_reg[qi][k]);
            end
            n_reg <= '0;
        end
        if (cmd.sq_en)
        begin
            n_reg <= n_reg + NW'(unsigned'(sq));
        end
        if (cmd.load_en)
        begin
            mag_reg <= mag_next;
            neg_reg <= s_reg[cmd.comp_sel][SUM_W-1];
            p_reg   <= n_ext;
            q_reg   <= -n_ext;
            r_reg   <= '0;
        end
        if (cmd.iter_en && (p_cand <= r2_eff(mag_sq)))
        begin
            p_reg <= p_cand;
            q_reg <= q_reg + (n_ext <<< ({1'b0, cmd.bit_sel} + 6'd1));
            r_reg <= r_reg | ((F + 1)'(1) << cmd.bit_sel);
        end
        if (cmd.store_en)
        begin
            pts_reg[cmd.edge_sel][cmd.comp_sel] <= res;
        end
        if (cmd.emit_load)
        begin
            index_overflow <= ovf_reg;
            last_of_run    <= (cmd.emit_sel == EMIT_INNER);
            case (cmd.emit_sel)
                EMIT_PAB, EMIT_PBC, EMIT_PCA:
                begin
                    item_kind        <= KIND_POINT;
                    out_index_first  <= nidx_reg[cmd.emit_sel[1:0]];
                    out_index_second <= '0;
                    out_index_third  <= '0;
                    point_x          <= pts_reg[cmd.emit_sel[1:0]][0];
                    point_y          <= pts_reg[cmd.emit_sel[1:0]][1];
                    point_z          <= pts_reg[cmd.emit_sel[1:0]][2];
                end
                EMIT_TRI_A:
                begin
                    item_kind        <= KIND_TRI;
                    out_index_first  <= ia_reg;
                    out_index_second <= nidx_reg[0];
                    out_index_third  <= nidx_reg[2];
                    point_x          <= '0;
                    point_y          <= '0;
                    point_z          <= '0;
                end
                EMIT_TRI_B:
                begin
                    item_kind        <= KIND_TRI;
                    out_index_first  <= ib_reg;
                    out_index_second <= nidx_reg[1];
                    out_index_third  <= nidx_reg[0];
                    point_x          <= '0;
                    point_y          <= '0;
                    point_z          <= '0;
                end
                EMIT_TRI_C:
                begin
                    item_kind        <= KIND_TRI;
                    out_index_first  <= ic_reg;
                    out_index_second <= nidx_reg[2];
                    out_index_third  <= nidx_reg[1];
                    point_x          <= '0;
                    point_y          <= '0;
                    point_z          <= '0;
                end
                default:
                begin
                    item_kind        <= KIND_TRI;
                    out_index_first  <= nidx_reg[0];
                    out_index_second <= nidx_reg[1];
                    out_index_third  <= nidx_reg[2];
                    point_x          <= '0;
                    point_y          <= '0;
                    point_z          <= '0;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/icotri_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module icotri_ctrl #(
    parameter int COORD_FRAC_BITS = icotri_pkg::DEF_FRAC_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    output icotri_pkg::cmd_t      cmd,
    input  wire icotri_pkg::sts_t sts
);
    import icotri_pkg::*;

    typedef enum logic [2:0] {IDLE, SUM, SQ, LOAD, ITER, STORE, EMIT} state_t;

    state_t           state_reg;
    logic [1:0]       edge_reg, comp_reg;
    logic [BIT_W-1:0] bit_reg;
    logic [2:0]       emit_reg;
    logic             out_valid_reg;
    logic             emit_go;

    assign in_ready  = (state_reg == IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign emit_go   = (state_reg == EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd           = '0;
        cmd.capture   = in_valid && in_ready;
        cmd.cfg_load  = cfg_valid;
        cmd.sum_en    = (state_reg == SUM);
        cmd.sq_en     = (state_reg == SQ);
        cmd.load_en   = (state_reg == LOAD);
        cmd.iter_en   = (state_reg == ITER);
        cmd.store_en  = (state_reg == STORE);
        cmd.emit_load = emit_go;
        cmd.edge_sel  = edge_reg;
        cmd.comp_sel  = comp_reg;
        cmd.bit_sel   = bit_reg;
        cmd.emit_sel  = emit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            edge_reg      <= '0;
            comp_reg      <= '0;
            bit_reg       <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        edge_reg  <= '0;
                        state_reg <= SUM;
                    end
                end
                SUM:
                begin
                    comp_reg  <= '0;
                    state_reg <= SQ;
                end
                SQ:
                begin
                    if (comp_reg == 2'd2)
                    begin
                        comp_reg  <= '0;
                        state_reg <= LOAD;
                    end
                    else
                    begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                LOAD:
                begin
                    bit_reg   <= BIT_W'(COORD_FRAC_BITS);
                    state_reg <= sts.n_zero ? STORE : ITER;
                end
                ITER:
                begin
                    if (bit_reg == '0)
                    begin
                        state_reg <= STORE;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - BIT_W'(1);
                    end
                end
                STORE:
                begin
                    if (comp_reg != 2'd2)
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= LOAD;
                    end
                    else if (edge_reg != 2'd2)
                    begin
                        edge_reg  <= edge_reg + 2'd1;
                        state_reg <= SUM;
                    end
                    else
                    begin
                        emit_reg  <= EMIT_PAB;
                        state_reg <= EMIT;
                    end
                end
                EMIT:
                begin
                    if (emit_go)
                    begin
                        if (emit_reg == EMIT_INNER)
                        begin
                            state_reg <= IDLE;
                        end
                        else
                        begin
                            emit_reg <= emit_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_iter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ITER |-> !sts.n_zero)
        else $error("normaliser iterating on zero-length sum");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == SUM && edge_reg == 2'd0)
        else $error("accepted request did not start edge sum");
    a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go && emit_reg == EMIT_INNER |=> state_reg == IDLE && out_valid_reg)
        else $error("final result not presented");
`endif
endmodule
`default_nettype wire
